// ===== src/mcbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Multicart bank mapper package
// Transfer types, address and data codes, game and mirroring codes, register
// region codes and serial loader constants shared by the bank mapper modules.
// ----------------------------------------------------------------------------
package mcbm_pkg;

	// One CPU write as it arrives on the write channel.
	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  data_byte;
	} wr_item_t;

	// The bank mapping that holds after one write.
	typedef struct packed {
		logic [6:0] prg_bank_slot0;
		logic [6:0] prg_bank_slot1;
		logic [6:0] prg_bank_slot2;
		logic [6:0] prg_bank_slot3;
		logic [5:0] chr_bank_low;
		logic [5:0] chr_bank_high;
		logic [1:0] mirroring;
		logic [1:0] selected_game;
	} map_item_t;

	// Menu unlock and game selection.
	localparam logic [15:0] UNLOCK_ADDR = 16'h8387;
	localparam logic [7:0]  UNLOCK_DATA = 8'h20;
	localparam logic [15:0] SELECT_ADDR = 16'h4120;
	localparam logic [7:0]  PICK_SERIAL = 8'h21;
	localparam logic [7:0]  PICK_DIRECT = 8'h62;

	// Selected game codes.
	localparam logic [1:0] GAME_MENU   = 2'd0;
	localparam logic [1:0] GAME_SERIAL = 2'd1;
	localparam logic [1:0] GAME_DIRECT = 2'd2;

	// Mirroring codes.
	localparam logic [1:0] MIRROR_HORIZ       = 2'd0;
	localparam logic [1:0] MIRROR_VERT        = 2'd1;
	localparam logic [1:0] MIRROR_SINGLE_LOW  = 2'd2;
	localparam logic [1:0] MIRROR_SINGLE_HIGH = 2'd3;

	// Serial register regions, taken from address bits 14:13.
	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_CHR0    = 2'd1;
	localparam logic [1:0] REG_CHR1    = 2'd2;
	localparam logic [1:0] REG_PRG     = 2'd3;

	// Serial loader details.
	localparam logic [4:0] CTL_RESET_BITS = 5'h0C;
	localparam logic [2:0] SHIFT_LEN      = 3'd5;

endpackage

// ===== src/mcbm_in_stage.sv =====
// ----------------------------------------------------------------------------
// Bank mapper input stage
// Holds one accepted CPU write until the mapping logic consumes it.
// ----------------------------------------------------------------------------
module mcbm_in_stage
	import mcbm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_stall,
	input  wr_item_t wr,
	input  logic     adv,
	output logic     item_valid,
	output wr_item_t item
);

	logic     valid_s1;
	wr_item_t item_s1;
	logic     take;

	// The held item leaves whenever the mapping logic advances.
	assign wr_stall = valid_s1 & ~adv;
	assign take     = wr_valid & ~wr_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= wr;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== src/mcbm_core.sv =====
// ----------------------------------------------------------------------------
// Bank mapper core
// Mapper state and the single-pass update that one CPU write applies to it.
// ----------------------------------------------------------------------------
module mcbm_core
	import mcbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  wr_item_t  item,
	output map_item_t next_map
);

	logic            unlocked_q, unlocked_d;
	logic [1:0]      game_q, game_d;
	logic [3:0][4:0] serial_q, serial_d;
	logic [2:0]      count_q, count_d;
	logic [4:0]      shbuf_q, shbuf_d;
	logic [1:0]      region_q, region_d;
	logic [3:0][6:0] prg_q, prg_d;
	logic [1:0][5:0] chr_q, chr_d;
	logic [1:0]      mirror_q, mirror_d;

	always_comb begin
		logic [1:0] region;
		logic [2:0] cnt;
		logic [4:0] sbuf;
		logic [4:0] ctl;
		logic [4:0] base5;
		logic [5:0] bank6;

		unlocked_d = unlocked_q;
		game_d     = game_q;
		serial_d   = serial_q;
		count_d    = count_q;
		shbuf_d    = shbuf_q;
		region_d   = region_q;
		prg_d      = prg_q;
		chr_d      = chr_q;
		mirror_d   = mirror_q;

		region = item.address[14:13];
		cnt    = count_q;
		sbuf   = shbuf_q;
		ctl    = serial_q[REG_CONTROL];
		base5  = {1'b0, serial_q[REG_PRG][4:1]} + 5'd4;
		bank6  = {1'b0, serial_q[REG_PRG]} + 6'd8;

		if (item.address[15]) begin
			if (item.address == UNLOCK_ADDR && item.data_byte == UNLOCK_DATA) begin
				unlocked_d = 1'b1;
				prg_d[0]   = 7'd4;
				prg_d[1]   = 7'd5;
				prg_d[2]   = 7'd6;
				prg_d[3]   = 7'd7;
			end
			case (game_q)
				GAME_SERIAL: begin
					// A change of register region restarts the serial load.
					if (region != region_q) begin
						cnt  = 3'd0;
						sbuf = 5'd0;
					end
					region_d = region;
					if (item.data_byte[7]) begin
						count_d               = 3'd0;
						shbuf_d               = 5'd0;
						serial_d[REG_CONTROL] = serial_q[REG_CONTROL] | CTL_RESET_BITS;
					end else begin
						if (item.data_byte[0]) begin
							sbuf = sbuf | (5'd1 << cnt);
						end
						cnt = cnt + 3'd1;
						if (cnt < SHIFT_LEN) begin
							count_d = cnt;
							shbuf_d = sbuf;
						end else begin
							count_d          = 3'd0;
							shbuf_d          = 5'd0;
							serial_d[region] = sbuf;
							ctl   = serial_d[REG_CONTROL];
							base5 = {1'b0, serial_d[REG_PRG][4:1]} + 5'd4;
							bank6 = {1'b0, serial_d[REG_PRG]} + 6'd8;
							case (region)
								REG_CONTROL: begin
									if (ctl[1]) begin
										mirror_d = ctl[0] ? MIRROR_HORIZ : MIRROR_VERT;
									end else begin
										mirror_d = ctl[0] ? MIRROR_SINGLE_HIGH
										                  : MIRROR_SINGLE_LOW;
									end
								end
								REG_CHR0, REG_CHR1: begin
									if (ctl[4]) begin
										chr_d[0] = {1'b1, serial_d[REG_CHR0]};
										chr_d[1] = {1'b1, serial_d[REG_CHR1]};
									end else begin
										chr_d[0] = {1'b1, serial_d[REG_CHR0][4:1], 1'b0};
										chr_d[1] = {1'b1, serial_d[REG_CHR0][4:1], 1'b1};
									end
								end
								REG_PRG: begin
									if (!ctl[3]) begin
										prg_d[0] = {base5, 2'd0};
										prg_d[1] = {base5, 2'd1};
										prg_d[2] = {base5, 2'd2};
										prg_d[3] = {base5, 2'd3};
									end else if (ctl[2]) begin
										prg_d[0] = {bank6, 1'b0};
										prg_d[1] = {bank6, 1'b1};
										prg_d[2] = 7'd62;
										prg_d[3] = 7'd63;
									end else begin
										prg_d[0] = 7'd16;
										prg_d[1] = 7'd17;
										prg_d[2] = {bank6, 1'b0};
										prg_d[3] = {bank6, 1'b1};
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				GAME_DIRECT: begin
					prg_d[0] = {3'd0, item.data_byte[6:4], 1'b0};
					prg_d[1] = {3'd0, item.data_byte[6:4], 1'b1};
					chr_d[0] = {1'b0, item.data_byte[3:0], 1'b0};
					chr_d[1] = {1'b0, item.data_byte[3:0], 1'b1};
					mirror_d = item.data_byte[7] ? MIRROR_HORIZ : MIRROR_VERT;
				end
				default: begin
				end
			endcase
		end else if (item.address == SELECT_ADDR && unlocked_q) begin
			if (item.data_byte == PICK_SERIAL) begin
				game_d   = GAME_SERIAL;
				prg_d[0] = 7'd28;
				prg_d[1] = 7'd29;
				prg_d[2] = 7'd30;
				prg_d[3] = 7'd31;
			end else if (item.data_byte == PICK_DIRECT) begin
				game_d   = GAME_DIRECT;
				prg_d[0] = 7'd12;
				prg_d[1] = 7'd13;
				prg_d[2] = 7'd14;
				prg_d[3] = 7'd15;
				chr_d[0] = 6'd0;
				chr_d[1] = 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlocked_q  <= 1'b0;
			game_q      <= GAME_MENU;
			serial_q[0] <= CTL_RESET_BITS;
			serial_q[1] <= 5'd0;
			serial_q[2] <= 5'd0;
			serial_q[3] <= 5'd0;
			count_q     <= 3'd0;
			shbuf_q     <= 5'd0;
			region_q    <= REG_CONTROL;
			prg_q[0]    <= 7'd0;
			prg_q[1]    <= 7'd1;
			prg_q[2]    <= 7'd6;
			prg_q[3]    <= 7'd7;
			chr_q[0]    <= 6'd0;
			chr_q[1]    <= 6'd1;
			mirror_q    <= MIRROR_VERT;
		end else if (adv) begin
			unlocked_q <= unlocked_d;
			game_q     <= game_d;
			serial_q   <= serial_d;
			count_q    <= count_d;
			shbuf_q    <= shbuf_d;
			region_q   <= region_d;
			prg_q      <= prg_d;
			chr_q      <= chr_d;
			mirror_q   <= mirror_d;
		end
	end

	assign next_map.prg_bank_slot0 = prg_d[0];
	assign next_map.prg_bank_slot1 = prg_d[1];
	assign next_map.prg_bank_slot2 = prg_d[2];
	assign next_map.prg_bank_slot3 = prg_d[3];
	assign next_map.chr_bank_low   = chr_d[0];
	assign next_map.chr_bank_high  = chr_d[1];
	assign next_map.mirroring      = mirror_d;
	assign next_map.selected_game  = game_d;

endmodule

// ===== src/mcbm_out_stage.sv =====
// ----------------------------------------------------------------------------
// Bank mapper result register
// Holds one finished mapping until the consumer takes it.
// ----------------------------------------------------------------------------
module mcbm_out_stage
	import mcbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  map_item_t next_map,
	output logic      map_valid,
	input  logic      map_stall,
	output map_item_t bank_map
);

	logic      valid_q;
	map_item_t map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & map_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			map_q <= next_map;
		end
	end

	assign map_valid = valid_q;
	assign bank_map  = map_q;

endmodule

// ===== src/multicart_mmc1_bank_mapper_top.sv =====
// ----------------------------------------------------------------------------
// Multicart bank mapper, top level
// Turns each CPU write to the cartridge into the bank mapping that holds after
// it: four 8K program banks, two 4K character banks, mirroring and the game.
// ----------------------------------------------------------------------------
// The block takes one CPU write per transfer on the write channel and returns
// exactly one mapping per write on the map channel, in order. A write is held
// in an input register, the mapping logic applies it to the mapper state, and
// the new mapping lands in a result register. One transfer can be accepted
// every clock cycle while the map side does not stall. A mapping is offered on
// the map channel once its write has passed the input register and the result
// register. While a finished mapping waits to be taken, the input register can
// still take one more write; after that the write side stalls until the map
// side takes the mapping. The rate is set by the state update, as each write
// depends on the state the one before it leaves. Writes below 0x4020, and
// low-area writes other than the game select at 0x4120, leave the state alone
// but still produce a mapping. After reset the mapping is program banks 0, 1,
// 6, 7, character banks 0 and 1, vertical mirroring and the menu.
module multicart_mmc1_bank_mapper_top
	import mcbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_stall,
	input  wr_item_t  wr,
	output logic      map_valid,
	input  logic      map_stall,
	output map_item_t bank_map
);

	logic      item_valid;
	wr_item_t  item;
	map_item_t next_map;
	logic      adv;

	// The held write is applied when the result register is free, or is being
	// emptied in this same cycle.
	assign adv = item_valid & ~(map_valid & map_stall);

	mcbm_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_valid   (wr_valid),
		.wr_stall   (wr_stall),
		.wr         (wr),
		.adv        (adv),
		.item_valid (item_valid),
		.item       (item)
	);

	mcbm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item),
		.next_map (next_map)
	);

	mcbm_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.next_map  (next_map),
		.map_valid (map_valid),
		.map_stall (map_stall),
		.bank_map  (bank_map)
	);

endmodule

// ===== src/mcbm_checker.sv =====
// ----------------------------------------------------------------------------
// Bank mapper port checker
// Watches the top level's ports for handshake and mapping consistency.
// ----------------------------------------------------------------------------
module mcbm_checker
	import mcbm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      wr_valid,
	input logic      wr_stall,
	input wr_item_t  wr,
	input logic      map_valid,
	input logic      map_stall,
	input map_item_t bank_map
);

	// A stalled write stays offered and unchanged.
	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_stall |=> wr_valid && $stable(wr))
		else $error("stalled write changed or was dropped");

	// A stalled result stays offered and unchanged.
	a_map_hold: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid && map_stall |=> map_valid && $stable(bank_map))
		else $error("stalled mapping changed or was dropped");

	// With no result waiting the block always takes a new write.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!map_valid |-> !wr_stall)
		else $error("write stalled while the result register is empty");

	// Program banks always come in even/odd pairs.
	a_prg_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid |-> !bank_map.prg_bank_slot0[0] && !bank_map.prg_bank_slot2[0]
			&& bank_map.prg_bank_slot1 == (bank_map.prg_bank_slot0 | 7'd1)
			&& bank_map.prg_bank_slot3 == (bank_map.prg_bank_slot2 | 7'd1))
		else $error("program bank slots not paired");

	// In the menu the character banks and mirroring keep their reset values.
	a_menu_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		map_valid && bank_map.selected_game == GAME_MENU |->
			bank_map.chr_bank_low == 6'd0 && bank_map.chr_bank_high == 6'd1
			&& bank_map.mirroring == MIRROR_VERT)
		else $error("menu mapping changed");

endmodule

bind multicart_mmc1_bank_mapper_top mcbm_checker u_mcbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.wr_valid  (wr_valid),
	.wr_stall  (wr_stall),
	.wr        (wr),
	.map_valid (map_valid),
	.map_stall (map_stall),
	.bank_map  (bank_map)
);
